// ----- src/assert_macros.svh -----
// assertion macros used by the checker file bmptw_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked in reset too
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/bmptw_pkg.sv -----
// ----------------------------------------------------------------------------
// bmptw_pkg
// shared types and constants of the bmp to rgba8 tile writer
// ----------------------------------------------------------------------------
package bmptw_pkg;

  localparam int COLOR_W     = 8;
  localparam int OFFSET_W    = 22;
  localparam int CFG_DATA_W  = 11;
  localparam int CFG_ADDR_W  = 2;

  localparam logic [COLOR_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [COLOR_W-1:0] ALPHA_CLEAR  = 8'h00;
  localparam logic [COLOR_W-1:0] FILL_COLOR   = 8'hFF;

  // register map of the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_BOTTOM_UP    = 2'd2
  } cfg_reg_t;

endpackage

// ----- src/bmptw_pixel_if.sv -----
// ----------------------------------------------------------------------------
// bmptw_pixel_if
// input pixel channel: one bgr pixel per transaction
// ----------------------------------------------------------------------------
interface bmptw_pixel_if;
  logic                          valid;
  logic                          ready;
  logic [bmptw_pkg::COLOR_W-1:0] blue;
  logic [bmptw_pkg::COLOR_W-1:0] green;
  logic [bmptw_pkg::COLOR_W-1:0] red;

  modport source (output valid, blue, green, red, input ready);
  modport sink   (input valid, blue, green, red, output ready);
endinterface

// ----- src/bmptw_cell_if.sv -----
// ----------------------------------------------------------------------------
// bmptw_cell_if
// output channel: one texture cell with its byte offset per transaction
// ----------------------------------------------------------------------------
interface bmptw_cell_if;
  logic                           valid;
  logic                           ready;
  logic [bmptw_pkg::OFFSET_W-1:0] tile_offset;
  logic [bmptw_pkg::COLOR_W-1:0]  alpha;
  logic [bmptw_pkg::COLOR_W-1:0]  red_out;
  logic [bmptw_pkg::COLOR_W-1:0]  green_out;
  logic [bmptw_pkg::COLOR_W-1:0]  blue_out;
  logic                           last;

  modport source (output valid, tile_offset, alpha, red_out, green_out, blue_out, last,
                  input ready);
  modport sink   (input valid, tile_offset, alpha, red_out, green_out, blue_out, last,
                  output ready);
endinterface

// ----- src/bmptw_cfg_if.sv -----
// ----------------------------------------------------------------------------
// bmptw_cfg_if
// configuration write channel: register address and write data
// ----------------------------------------------------------------------------
interface bmptw_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [bmptw_pkg::CFG_ADDR_W-1:0] addr;
  logic [bmptw_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ----- src/bmp_to_rgba8_tile_writer.sv -----
// ----------------------------------------------------------------------------
// bmp_to_rgba8_tile_writer
// maps a stream of bmp pixels onto a 4x4-tiled rgba8 texture layout
// ----------------------------------------------------------------------------
// Pixels arrive in file order (rows top-down, or bottom-up when bottom_up is
// set) with row padding already stripped. Each pixel leaves as one cell with
// alpha 255 and the byte offset of its alpha-red pair; the green-blue pair
// goes at tile_offset + 32. A pixel in the last column or the bottom image row
// also produces transparent fill cells (alpha 0, colors 255) up to the next
// multiple of 4, in raster order, with last set on its final cell. Throughput
// is one pixel per clock for interior pixels when not stalled; an edge pixel
// occupies the cell emitter until all its cells (up to 16) are loaded, during
// which no new pixel is taken. A pixel goes through the job registers and the
// output register. A write to a known register restarts at the first pixel.
// ----------------------------------------------------------------------------
module bmp_to_rgba8_tile_writer #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic               clk,
  input  logic               rst,
  bmptw_pixel_if.sink        pix,
  bmptw_cell_if.source       texel,
  bmptw_cfg_if.sink          cfg
);

  localparam int XW = $clog2(MAX_WIDTH + 4);
  localparam int YW = $clog2(MAX_HEIGHT + 4);
  localparam int TW = XW - 2;
  localparam int TY = YW - 2;

  // image geometry, clamped on write
  logic [XW-1:0] img_w;
  logic [YW-1:0] img_h;
  logic          bottom_up;
  logic [XW-1:0] img_w4;
  logic [YW-1:0] img_h4;
  logic [TW-1:0] tiles_per_row;

  // pixel position counters
  logic [XW-1:0] column_count;
  logic [YW-1:0] row_count;

  // cell emitter state
  logic                          job_valid;
  logic                          job_first;
  logic [XW-1:0]                 cx;
  logic [YW-1:0]                 cy;
  logic [XW-1:0]                 x0;
  logic [XW-1:0]                 xend;
  logic [YW-1:0]                 yend;
  logic [bmptw_pkg::COLOR_W-1:0] job_red;
  logic [bmptw_pkg::COLOR_W-1:0] job_green;
  logic [bmptw_pkg::COLOR_W-1:0] job_blue;

  // output register
  logic                           out_valid;
  logic [bmptw_pkg::OFFSET_W-1:0] out_offset;
  logic [bmptw_pkg::COLOR_W-1:0]  out_alpha;
  logic [bmptw_pkg::COLOR_W-1:0]  out_red;
  logic [bmptw_pkg::COLOR_W-1:0]  out_green;
  logic [bmptw_pkg::COLOR_W-1:0]  out_blue;
  logic                           out_last;

  logic          load;
  logic          job_last_cell;
  logic          accept;
  logic [YW-1:0] y_in;
  logic [XW-1:0] xend_in;
  logic [YW-1:0] yend_in;
  logic [TY+TW-1:0] tile_base;
  logic [31:0]   tile_index;
  logic [31:0]   offset_full;
  logic          cfg_write;

  // padded dimensions
  assign img_w4        = (img_w + XW'(3)) & ~XW'(3);
  assign img_h4        = (img_h + YW'(3)) & ~YW'(3);
  assign tiles_per_row = img_w4[XW-1:2];

  // handshakes
  assign cfg.ready     = 1'b1;
  assign cfg_write     = cfg.valid;
  assign load          = job_valid && (!out_valid || texel.ready);
  assign job_last_cell = (cx == xend) && (cy == yend);
  assign pix.ready     = !job_valid || (load && job_last_cell);
  assign accept        = pix.valid && pix.ready;

  // extent of the cell rectangle for an incoming pixel
  always_comb begin
    y_in    = bottom_up ? (img_h - YW'(1) - row_count) : row_count;
    yend_in = (y_in == img_h - YW'(1)) ? (img_h4 - YW'(1)) : y_in;
    xend_in = (column_count == img_w - XW'(1)) ? (img_w4 - XW'(1)) : column_count;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      img_w     <= XW'(1);
      img_h     <= YW'(1);
      bottom_up <= 1'b1;
    end else if (cfg_write) begin
      case (bmptw_pkg::cfg_reg_t'(cfg.addr))
        bmptw_pkg::REG_IMAGE_WIDTH: begin
          if (cfg.data == '0) begin
            img_w <= XW'(1);
          end else if (32'(cfg.data) > 32'(MAX_WIDTH)) begin
            img_w <= XW'(MAX_WIDTH);
          end else begin
            img_w <= XW'(cfg.data);
          end
        end
        bmptw_pkg::REG_IMAGE_HEIGHT: begin
          if (cfg.data == '0) begin
            img_h <= YW'(1);
          end else if (32'(cfg.data) > 32'(MAX_HEIGHT)) begin
            img_h <= YW'(MAX_HEIGHT);
          end else begin
            img_h <= YW'(cfg.data);
          end
        end
        bmptw_pkg::REG_BOTTOM_UP: begin
          bottom_up <= cfg.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // column and row counters, restarted by any known register write
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_write && (cfg.addr == bmptw_pkg::REG_IMAGE_WIDTH ||
                               cfg.addr == bmptw_pkg::REG_IMAGE_HEIGHT ||
                               cfg.addr == bmptw_pkg::REG_BOTTOM_UP)) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (column_count == img_w - XW'(1)) begin
        column_count <= '0;
        if (row_count == img_h - YW'(1)) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + YW'(1);
        end
      end else begin
        column_count <= column_count + XW'(1);
      end
    end
  end

  // emitter control
  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept) begin
      job_valid <= 1'b1;
    end else if (load && job_last_cell) begin
      job_valid <= 1'b0;
    end
  end

  // emitter position and pixel data
  always_ff @(posedge clk) begin
    if (accept) begin
      job_first <= 1'b1;
      cx        <= column_count;
      cy        <= y_in;
      x0        <= column_count;
      xend      <= xend_in;
      yend      <= yend_in;
      job_red   <= pix.red;
      job_green <= pix.green;
      job_blue  <= pix.blue;
    end else if (load) begin
      job_first <= 1'b0;
      if (cx == xend) begin
        cx <= x0;
        cy <= cy + YW'(1);
      end else begin
        cx <= cx + XW'(1);
      end
    end
  end

  // byte offset of the current cell
  always_comb begin
    tile_base   = cy[YW-1:2] * tiles_per_row;
    tile_index  = 32'(tile_base) + 32'(cx[XW-1:2]);
    offset_full = (tile_index << 6) | 32'({cy[1:0], cx[1:0], 1'b0});
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (texel.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_offset <= offset_full[bmptw_pkg::OFFSET_W-1:0];
      out_last   <= job_last_cell;
      if (job_first) begin
        out_alpha <= bmptw_pkg::ALPHA_OPAQUE;
        out_red   <= job_red;
        out_green <= job_green;
        out_blue  <= job_blue;
      end else begin
        out_alpha <= bmptw_pkg::ALPHA_CLEAR;
        out_red   <= bmptw_pkg::FILL_COLOR;
        out_green <= bmptw_pkg::FILL_COLOR;
        out_blue  <= bmptw_pkg::FILL_COLOR;
      end
    end
  end

  assign texel.valid       = out_valid;
  assign texel.tile_offset = out_offset;
  assign texel.alpha       = out_alpha;
  assign texel.red_out     = out_red;
  assign texel.green_out   = out_green;
  assign texel.blue_out    = out_blue;
  assign texel.last        = out_last;

endmodule

// ----- src/bmptw_checker.sv -----
// ----------------------------------------------------------------------------
// bmptw_checker
// port-level checks on the output channel of the tile writer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmptw_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           cell_valid,
  input logic                           cell_ready,
  input logic [bmptw_pkg::OFFSET_W-1:0] tile_offset,
  input logic [bmptw_pkg::COLOR_W-1:0]  alpha,
  input logic [bmptw_pkg::COLOR_W-1:0]  red_out,
  input logic [bmptw_pkg::COLOR_W-1:0]  green_out,
  input logic [bmptw_pkg::COLOR_W-1:0]  blue_out,
  input logic                           last
);

  // a stalled cell holds its offset, alpha and last
  `ASSERT_NEXT(a_stall_hold, clk, rst, cell_valid && !cell_ready,
    cell_valid && $stable(tile_offset) && $stable(alpha) && $stable(last),
    "stalled cell changed")

  // cells that are not image pixels are transparent white fill
  `ASSERT_IMPLIES(a_fill_cell, clk, rst, cell_valid && alpha != bmptw_pkg::ALPHA_OPAQUE,
    alpha == bmptw_pkg::ALPHA_CLEAR && red_out == bmptw_pkg::FILL_COLOR &&
    green_out == bmptw_pkg::FILL_COLOR && blue_out == bmptw_pkg::FILL_COLOR,
    "bad fill cell")

  // alpha-red pairs are even and in the first half of a tile
  `ASSERT_IMPLIES(a_offset_align, clk, rst, cell_valid,
    !tile_offset[0] && !tile_offset[5], "misplaced tile offset")

  // nothing leaves the block right after reset
  `ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, rst, !cell_valid, "cell valid after reset")

endmodule

bind bmp_to_rgba8_tile_writer bmptw_checker u_bmptw_checker (
  .clk         (clk),
  .rst         (rst),
  .cell_valid  (texel.valid),
  .cell_ready  (texel.ready),
  .tile_offset (texel.tile_offset),
  .alpha       (texel.alpha),
  .red_out     (texel.red_out),
  .green_out   (texel.green_out),
  .blue_out    (texel.blue_out),
  .last        (texel.last)
);
